FILE: rtl/core/qcwa_pkg.sv
// qcwa_pkg: shared types and fixed widths for the quad corner warp address block
// used by qcwa_axis and quad_corner_warp_address, depends on nothing else

package qcwa_pkg;

    localparam int CORNER_W = 18;   // signed q3.14 corner coordinate
    localparam int FRAC_W   = 14;   // fraction bits of a corner coordinate
    localparam int COORD_W  = 10;   // source and destination coordinate ports
    localparam int PIX_W    = 32;   // packed rgba pixel
    localparam int INDEX_W  = 20;   // linear destination address
    localparam int TW       = 32;   // row blend, signed, sized for frames up to 4096
    localparam int NW       = 46;   // full blend numerator, signed
    localparam int AXIS_LAT = 9;    // register stages in one axis pipeline

    localparam logic signed [CORNER_W-1:0] Q14_ONE = CORNER_W'(16384);

    typedef enum logic [2:0] {
        CFG_TLX,
        CFG_TLY,
        CFG_TRX,
        CFG_TRY,
        CFG_BLX,
        CFG_BLY,
        CFG_BRX,
        CFG_BRY
    } t_cfg_idx;

    // one coordinate of all four corners
    typedef struct packed {
        logic [CORNER_W-1:0] tl;
        logic [CORNER_W-1:0] tr;
        logic [CORNER_W-1:0] bl;
        logic [CORNER_W-1:0] br;
    } t_corners;

endpackage

FILE: rtl/core/quad_corner_warp_address.sv
// quad_corner_warp_address: top level, corner registers, two axis pipelines,
// pixel delay line and destination index; uses qcwa_pkg and qcwa_axis
//
//   channel   ports                                        transfer
//   source    start, busy, i_pixel_value, i_source_x/_y    start high, busy low
//   result    o_valid, o_dest_x/_y, o_dest_index,          o_valid high, one cycle
//             o_pixel_out, o_in_range
//   config    i_cfg_we, i_cfg_index, i_cfg_data            i_cfg_we high
//
// one pixel is taken every clock; busy stays low
// the result passes nine register stages in each axis pipeline (blend
// multipliers, reciprocal multiply, remainder correction, rounding) and one
// stage for the linear index multiply
// reset is synchronous and loads the corner defaults and clears the valid bits
// the receiver cannot stall, so nothing is ever held back

module quad_corner_warp_address import qcwa_pkg::*; #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [PIX_W-1:0]    i_pixel_value,
    input  logic [COORD_W-1:0]  i_source_x,
    input  logic [COORD_W-1:0]  i_source_y,
    output logic                o_valid,
    output logic [COORD_W-1:0]  o_dest_x,
    output logic [COORD_W-1:0]  o_dest_y,
    output logic [INDEX_W-1:0]  o_dest_index,
    output logic [PIX_W-1:0]    o_pixel_out,
    output logic                o_in_range,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [CORNER_W-1:0] i_cfg_data
);

    localparam int CWX = $clog2(FRAME_WIDTH + 1);
    localparam int CWY = $clog2(FRAME_HEIGHT + 1);
    localparam int IW  = 32;
    localparam int PIPE_LAT = AXIS_LAT + 1;

    logic [CORNER_W-1:0] r_tlx, r_tly, r_trx, r_try, r_blx, r_bly, r_brx, r_bry;
    logic [PIX_W-1:0]    r_pix_q [AXIS_LAT];

    logic                r_valid, r_in_range;
    logic [COORD_W-1:0]  r_dest_x, r_dest_y;
    logic [INDEX_W-1:0]  r_dest_index;
    logic [PIX_W-1:0]    r_pixel;

    t_corners         w_cx, w_cy;
    logic             w_accept;
    logic             w_x_valid, w_y_valid, w_x_ok, w_y_ok, w_ok;
    logic [CWX-1:0]   w_rx;
    logic [CWY-1:0]   w_ry;
    logic [CWX+COORD_W-1:0] w_rx_ext;
    logic [CWY+COORD_W-1:0] w_ry_ext;
    logic [IW-1:0]    w_index;

    // the pipeline takes a transfer every cycle
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_cx = '{tl: r_tlx, tr: r_trx, bl: r_blx, br: r_brx};
    assign w_cy = '{tl: r_tly, tr: r_try, bl: r_bly, br: r_bry};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlx <= '0;
            r_tly <= '0;
            r_trx <= Q14_ONE;
            r_try <= '0;
            r_blx <= '0;
            r_bly <= Q14_ONE;
            r_brx <= Q14_ONE;
            r_bry <= Q14_ONE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TLX: r_tlx <= i_cfg_data;
                CFG_TLY: r_tly <= i_cfg_data;
                CFG_TRX: r_trx <= i_cfg_data;
                CFG_TRY: r_try <= i_cfg_data;
                CFG_BLX: r_blx <= i_cfg_data;
                CFG_BLY: r_bly <= i_cfg_data;
                CFG_BRX: r_brx <= i_cfg_data;
                CFG_BRY: r_bry <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // x is divided by the frame height, y by the frame width
    qcwa_axis #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .DIV          (FRAME_HEIGHT),
        .LIMIT        (FRAME_WIDTH)
    ) u_axis_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_corners (w_cx),
        .i_x       (i_source_x),
        .i_y       (i_source_y),
        .o_valid   (w_x_valid),
        .o_coord   (w_rx),
        .o_ok      (w_x_ok)
    );

    qcwa_axis #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .DIV          (FRAME_WIDTH),
        .LIMIT        (FRAME_HEIGHT)
    ) u_axis_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_corners (w_cy),
        .i_x       (i_source_x),
        .i_y       (i_source_y),
        .o_valid   (w_y_valid),
        .o_coord   (w_ry),
        .o_ok      (w_y_ok)
    );

    always_ff @(posedge i_clk) begin
        r_pix_q[0] <= i_pixel_value;
        for (int i = 1; i < AXIS_LAT; i++) begin
            r_pix_q[i] <= r_pix_q[i-1];
        end
    end

    assign w_ok     = w_x_ok && w_y_ok;
    assign w_rx_ext = {{COORD_W{1'b0}}, w_rx};
    assign w_ry_ext = {{COORD_W{1'b0}}, w_ry};
    assign w_index  = IW'(w_rx) + IW'(FRAME_WIDTH) * IW'(w_ry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_range   <= w_x_valid && w_ok;
        r_dest_x     <= w_ok ? w_rx_ext[COORD_W-1:0] : '0;
        r_dest_y     <= w_ok ? w_ry_ext[COORD_W-1:0] : '0;
        r_dest_index <= w_ok ? w_index[INDEX_W-1:0] : '0;
        r_pixel      <= r_pix_q[AXIS_LAT-1];
    end

    assign o_valid      = r_valid;
    assign o_dest_x     = r_dest_x;
    assign o_dest_y     = r_dest_y;
    assign o_dest_index = r_dest_index;
    assign o_pixel_out  = r_pixel;
    assign o_in_range   = r_in_range;

    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, PIPE_LAT))
        else $error("result without a matching source transfer");

    a_axes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_x_valid == w_y_valid)
        else $error("axis pipelines out of step");

    a_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |->
            (o_dest_x == '0) && (o_dest_y == '0) && (o_dest_index == '0))
        else $error("dropped target carries a non-zero address");

    a_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_in_range)
        else $error("in range flag raised without a result");

endmodule

FILE: rtl/core/qcwa_axis.sv
// qcwa_axis: one axis of the warp, bilinear blend of the corners and exact
// round-to-nearest-even division by DIV*16384, then range check; uses qcwa_pkg

module qcwa_axis import qcwa_pkg::*; #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024,
    parameter int DIV          = 1024,
    parameter int LIMIT        = 1024,
    localparam int CW          = $clog2(LIMIT + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  t_corners       i_corners,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    output logic           o_valid,
    output logic [CW-1:0]  o_coord,
    output logic           o_ok
);

    localparam int DFW = CORNER_W + 1;
    localparam int QW  = $clog2(LIMIT + 2);
    localparam int MW  = $clog2((LIMIT + 1) * DIV + 1);
    localparam int RS  = MW;
    localparam int RMW = $clog2(2 * DIV + 1);
    localparam int HW  = NW - FRAC_W + 1;
    localparam int PW  = MW + RS + 1;

    localparam logic signed [TW-1:0] W_S   = TW'(FRAME_WIDTH);
    localparam logic signed [NW-1:0] H_S   = NW'(FRAME_HEIGHT);
    localparam logic signed [HW-1:0] DIV_S = HW'(DIV);
    localparam logic signed [HW-1:0] BIG_S = HW'((LIMIT + 1) * DIV);
    localparam logic [RS:0]          RECIP = (RS + 1)'((64'd1 << RS) / DIV);
    localparam logic [MW:0]          DIV_M = (MW + 1)'(DIV);
    localparam logic [RMW-1:0]       DIV_R = RMW'(DIV);
    localparam logic [RMW+FRAC_W-1:0] HALF = (RMW + FRAC_W)'(DIV) << (FRAC_W - 1);
    localparam logic [QW:0]          LIM_Q = (QW + 1)'(LIMIT);

    logic [AXIS_LAT-1:0] r_v;

    // stage 1: corner scaling and edge deltas
    logic signed [TW-1:0]  r1_tlw, r1_blw;
    logic signed [DFW-1:0] r1_dt, r1_db;
    logic [COORD_W-1:0]    r1_x, r1_y;
    // stage 2: top and bottom edge points
    logic signed [TW-1:0]  r2_tx, r2_bx;
    logic [COORD_W-1:0]    r2_y;
    // stage 3: products of the vertical blend
    logic signed [NW-1:0]  r3_p1, r3_p2;
    // stage 4: numerator
    logic signed [NW-1:0]  r4_n;
    // stage 5 onwards: offset quotient search
    logic [MW-1:0]         r5_m, r6_m;
    logic [FRAC_W-1:0]     r5_nl, r6_nl, r7_nl, r8_nl;
    logic                  r5_out, r6_out, r7_out, r8_out;
    logic [QW-1:0]         r6_qe, r7_qe, r8_qp;
    logic [RMW-1:0]        r7_rem, r8_rem;
    logic [CW-1:0]         r9_coord;
    logic                  r9_ok;

    logic signed [TW-1:0]  w_tx, w_bx;
    logic signed [TW:0]    w_d;
    logic signed [HW-1:0]  w_m;
    logic [PW-1:0]         w_prod;
    logic [MW:0]           w_qd, w_diff;
    logic [RMW+FRAC_W-1:0] w_r;
    logic                  w_up;
    logic [QW:0]           w_sum, w_rx;

    assign w_tx = r1_tlw + TW'(r1_dt) * $signed({{(TW - COORD_W){1'b0}}, r1_x});
    assign w_bx = r1_blw + TW'(r1_db) * $signed({{(TW - COORD_W){1'b0}}, r1_x});
    assign w_d  = (TW + 1)'(r2_bx) - (TW + 1)'(r2_tx);

    // floor by 2^14 first, offset by one divisor so the window of interest is non-negative
    assign w_m    = HW'($signed(r4_n[NW-1:FRAC_W])) + DIV_S;
    assign w_prod = PW'(r5_m) * PW'(RECIP);
    assign w_qd   = (MW + 1)'(r6_qe) * DIV_M;
    assign w_diff = {1'b0, r6_m} - w_qd;

    // remainder against half the divisor, ties go to the even quotient
    // (the held quotient is one above the true one, so its parity is inverted)
    assign w_r   = {r8_rem, r8_nl};
    assign w_up  = (w_r > HALF) || ((w_r == HALF) && !r8_qp[0]);
    assign w_sum = {1'b0, r8_qp} + (QW + 1)'(w_up);
    assign w_rx  = w_sum - (QW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[AXIS_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_tlw <= TW'($signed(i_corners.tl)) * W_S;
        r1_blw <= TW'($signed(i_corners.bl)) * W_S;
        r1_dt  <= DFW'($signed(i_corners.tr)) - DFW'($signed(i_corners.tl));
        r1_db  <= DFW'($signed(i_corners.br)) - DFW'($signed(i_corners.bl));
        r1_x   <= i_x;
        r1_y   <= i_y;

        r2_tx <= w_tx;
        r2_bx <= w_bx;
        r2_y  <= r1_y;

        r3_p1 <= NW'(r2_tx) * H_S;
        r3_p2 <= NW'(w_d) * $signed({{(NW - COORD_W){1'b0}}, r2_y});

        r4_n <= r3_p1 + r3_p2;

        r5_out <= (w_m < 0) || (w_m >= BIG_S);
        r5_m   <= w_m[MW-1:0];
        r5_nl  <= r4_n[FRAC_W-1:0];

        r6_qe  <= w_prod[RS +: QW];
        r6_m   <= r5_m;
        r6_nl  <= r5_nl;
        r6_out <= r5_out;

        r7_rem <= w_diff[RMW-1:0];
        r7_qe  <= r6_qe;
        r7_nl  <= r6_nl;
        r7_out <= r6_out;

        // reciprocal estimate can be one short
        if (r7_rem >= DIV_R) begin
            r8_qp  <= r7_qe + QW'(1);
            r8_rem <= r7_rem - DIV_R;
        end else begin
            r8_qp  <= r7_qe;
            r8_rem <= r7_rem;
        end
        r8_nl  <= r7_nl;
        r8_out <= r7_out;

        r9_coord <= w_rx[CW-1:0];
        r9_ok    <= !r8_out && (w_sum != '0) && (w_sum <= LIM_Q);
    end

    assign o_valid = r_v[AXIS_LAT-1];
    assign o_coord = r9_coord;
    assign o_ok    = r9_ok;

endmodule
